### rtl/bpfe_pkg.sv
// Shared types, constants and helper functions of the block parity frame encoder.
// Depends on nothing; the framer and the top level refer to it by scoped names.
package bpfe_pkg;

  localparam int MAX_LEN    = 64;
  localparam int NUM_SLICES = (MAX_LEN + 7) / 8;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int SLICE_W    = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] START_BYTE    = 8'h0D;
  localparam logic [BYTE_W-1:0] NO_START_BYTE = 8'h20;
  localparam logic [BYTE_W-1:0] END_BYTE      = 8'h0A;
  localparam logic [BYTE_W-1:0] PARITY_OFFSET = 8'd64;

  // Slice index of the last slice of a full-length message.
  localparam logic [SLICE_W-1:0] LAST_SLICE = SLICE_W'((MAX_LEN - 1) / 8);

  typedef enum logic [1:0] {
    REG_PARITY_ENABLE  = 2'd0,
    REG_SUPPRESS_START = 2'd1,
    REG_SUPPRESS_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BYTE,
    ST_PAR_RD,
    ST_PAR,
    ST_END
  } state_t;

  typedef struct packed {
    logic parity_enable;
    logic suppress_start;
    logic suppress_end;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_done;
    logic              overflow;
  } emit_t;

  // A slice XOR below 64 as a signed byte gets 64 added, modulo 256.
  function automatic logic [BYTE_W-1:0] adjust(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] res;
    res = x;
    if (x[7:6] != 2'b01) begin
      res = x + PARITY_OFFSET;
    end
    return res;
  endfunction

endpackage

### rtl/bpfe_slice_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read data.
// Depends on nothing; used for the per-slice XOR store.
module bpfe_slice_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bpfe_framer.sv
// Frame sequencer: takes message bytes, keeps the slice XORs in the slice RAM and
// emits start, data, parity and end bytes. Depends on bpfe_pkg and bpfe_slice_ram.
module bpfe_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  bpfe_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpfe_pkg::BYTE_W-1:0]   in_data,
  input  logic                          in_last,
  output logic                          emit_valid,
  input  logic                          emit_ready,
  output bpfe_pkg::emit_t               emit
);

  bpfe_pkg::state_t state, state_next;

  logic [bpfe_pkg::CNT_W-1:0]   count;
  logic [bpfe_pkg::BYTE_W-1:0]  run_xor;
  logic                         ovf_seen;
  logic [bpfe_pkg::BYTE_W-1:0]  byte_q;
  logic                         last_q;
  logic                         ovf_q;
  logic [bpfe_pkg::SLICE_W-1:0] idx;

  logic                         accept;
  logic                         full;
  logic [bpfe_pkg::SLICE_W-1:0] slot;
  logic [bpfe_pkg::BYTE_W-1:0]  xor_new;
  logic                         ram_re;
  logic [bpfe_pkg::BYTE_W-1:0]  ram_rdata;
  logic                         byte_fin;
  logic                         par_fin;

  assign accept   = in_valid && in_ready;
  assign full     = (count >= bpfe_pkg::CNT_W'(bpfe_pkg::MAX_LEN));
  assign slot     = bpfe_pkg::SLICE_W'(count >> 3);
  assign xor_new  = run_xor ^ in_data;
  // The data byte closes the item when no trailer byte follows it.
  assign byte_fin = !last_q || (!cfg.parity_enable && cfg.suppress_end);
  assign par_fin  = (idx == '0) && cfg.suppress_end;

  bpfe_slice_ram #(
    .DEPTH (bpfe_pkg::NUM_SLICES),
    .WIDTH (bpfe_pkg::BYTE_W),
    .ADDR_W(bpfe_pkg::SLICE_W)
  ) u_slice_ram (
    .clk  (clk),
    .we   (accept && !full),
    .waddr(slot),
    .wdata(xor_new),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      bpfe_pkg::ST_IDLE: begin
        if (accept) begin
          if (!full) begin
            state_next = (count == '0) ? bpfe_pkg::ST_START : bpfe_pkg::ST_BYTE;
          end else if (in_last) begin
            if (cfg.parity_enable) begin
              state_next = bpfe_pkg::ST_PAR_RD;
            end else if (!cfg.suppress_end) begin
              state_next = bpfe_pkg::ST_END;
            end
          end
        end
      end
      bpfe_pkg::ST_START: begin
        if (emit_ready) begin
          state_next = bpfe_pkg::ST_BYTE;
        end
      end
      bpfe_pkg::ST_BYTE: begin
        if (emit_ready) begin
          if (!last_q) begin
            state_next = bpfe_pkg::ST_IDLE;
          end else if (cfg.parity_enable) begin
            state_next = bpfe_pkg::ST_PAR_RD;
          end else if (!cfg.suppress_end) begin
            state_next = bpfe_pkg::ST_END;
          end else begin
            state_next = bpfe_pkg::ST_IDLE;
          end
        end
      end
      bpfe_pkg::ST_PAR_RD: begin
        state_next = bpfe_pkg::ST_PAR;
      end
      bpfe_pkg::ST_PAR: begin
        if (emit_ready) begin
          if (idx != '0) begin
            state_next = bpfe_pkg::ST_PAR_RD;
          end else if (!cfg.suppress_end) begin
            state_next = bpfe_pkg::ST_END;
          end else begin
            state_next = bpfe_pkg::ST_IDLE;
          end
        end
      end
      bpfe_pkg::ST_END: begin
        if (emit_ready) begin
          state_next = bpfe_pkg::ST_IDLE;
        end
      end
      default: state_next = bpfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    emit_valid      = 1'b0;
    ram_re          = 1'b0;
    emit.out_byte   = byte_q;
    emit.run_last   = 1'b0;
    emit.frame_done = 1'b0;
    emit.overflow   = ovf_q;
    unique case (state)
      bpfe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      bpfe_pkg::ST_START: begin
        emit_valid    = 1'b1;
        emit.out_byte = cfg.suppress_start ? bpfe_pkg::NO_START_BYTE
                                           : bpfe_pkg::START_BYTE;
      end
      bpfe_pkg::ST_BYTE: begin
        emit_valid      = 1'b1;
        emit.run_last   = byte_fin;
        emit.frame_done = byte_fin && last_q;
      end
      bpfe_pkg::ST_PAR_RD: begin
        ram_re = 1'b1;
      end
      bpfe_pkg::ST_PAR: begin
        emit_valid      = 1'b1;
        emit.out_byte   = bpfe_pkg::adjust(ram_rdata);
        emit.run_last   = par_fin;
        emit.frame_done = par_fin;
      end
      bpfe_pkg::ST_END: begin
        emit_valid      = 1'b1;
        emit.out_byte   = bpfe_pkg::END_BYTE;
        emit.run_last   = 1'b1;
        emit.frame_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpfe_pkg::ST_IDLE;
      count    <= '0;
      run_xor  <= '0;
      ovf_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_last) begin
          count    <= '0;
          run_xor  <= '0;
          ovf_seen <= 1'b0;
        end else if (full) begin
          ovf_seen <= 1'b1;
        end else begin
          count   <= count + 1'b1;
          run_xor <= (count[2:0] == 3'd7) ? '0 : xor_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= in_data;
      last_q <= in_last;
      ovf_q  <= full || ovf_seen;
      idx    <= full ? bpfe_pkg::LAST_SLICE : slot;
    end else if (state == bpfe_pkg::ST_PAR && emit_ready && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

endmodule

### rtl/block_parity_frame_encoder_unit.sv
// Top level of the block parity frame encoder: configuration registers, framer and
// output register. Depends on bpfe_pkg and bpfe_framer.
//
// The block takes one message byte per input word and frames it: the first byte of
// a message is preceded by a start byte 0x0D (0x20 with start suppression), every
// accepted byte within MAX_LEN is passed through, and after the byte marked last
// the block sends, with parity enabled, one control byte per 8-byte slice, last
// slice first, followed by the end byte 0x0A unless end suppression is on. Each
// control byte is the XOR of its slice, with 64 added (modulo 256) when the XOR
// is below 64 as a signed byte. Bytes past MAX_LEN (64) are dropped and the
// overflow flag rides on every later word of that frame. The slice XORs live in a
// small synchronous RAM that is written as bytes arrive and read back one slice at
// a time for the trailer. The framer takes one input word at a time; a byte passes
// the byte state, the first byte of a message the start state before it, each
// control byte a RAM read state and then the parity state, the end byte the end
// state; a dropped byte that is not last leaves the framer idle. An emitting state
// stalls while the output register holds an undrained word. Configuration is
// written through the cfg channel, which is always ready; writes must be made
// while the block is idle. Register 0 is parity_enable (reset 1), register 1
// suppress_start, register 2 suppress_end; only bit 0 of the data is used and
// other indexes are ignored.
module block_parity_frame_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte [7:0]
  input  logic       s_tlast,   // last_byte
  // Output stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte [7:0]
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser,   // frame_done [0], overflow [1]
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  bpfe_pkg::cfg_t  cfg;
  bpfe_pkg::emit_t emit;
  logic            emit_valid;
  logic            emit_ready;

  // Configuration registers are always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parity_enable  <= 1'b1;
      cfg.suppress_start <= 1'b0;
      cfg.suppress_end   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpfe_pkg::REG_PARITY_ENABLE:  cfg.parity_enable  <= cfg_data;
        bpfe_pkg::REG_SUPPRESS_START: cfg.suppress_start <= cfg_data;
        bpfe_pkg::REG_SUPPRESS_END:   cfg.suppress_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bpfe_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .emit_valid(emit_valid),
    .emit_ready(emit_ready),
    .emit      (emit)
  );

  // The output register takes a new word when it is empty or being drained.
  assign emit_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ready) begin
      m_tvalid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      m_tdata    <= emit.out_byte;
      m_tlast    <= emit.run_last;
      m_tuser[0] <= emit.frame_done;
      m_tuser[1] <= emit.overflow;
    end
  end

endmodule
